// ===== hdl/tte_pkg.sv =====
// shared types, constants and tables for the tap tempo estimator
`timescale 1ns / 1ps
package tte_pkg;

	// tap history depth and derived widths
	localparam int HISTORY_DEPTH = 8;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
	localparam int HELD_W        = $clog2(HISTORY_DEPTH + 1);
	localparam int TIME_W        = 48;
	localparam int SOURCE_W      = 2;
	localparam int BPM_W         = 15;

	// timing limits in microseconds
	localparam logic signed [TIME_W:0] GAP_RESET_US = (TIME_W + 1)'(2000000);
	localparam logic signed [TIME_W:0] GAP_MIN_US   = (TIME_W + 1)'(250000);
	localparam logic signed [TIME_W:0] GAP_MAX_US   = (TIME_W + 1)'(1000000);

	// one minute in microseconds times one hundred
	localparam logic [63:0] CENTI_MINUTE_US = 64'd6000000000;
	localparam int NUM_W = $clog2(CENTI_MINUTE_US * (HISTORY_DEPTH - 1) + 1);
	localparam int CNT_W = $clog2(NUM_W + 1);

	localparam logic [BPM_W-1:0] BPM_CENTI_LOW  = BPM_W'(6000);
	localparam logic [BPM_W-1:0] BPM_CENTI_HIGH = BPM_W'(20000);

	// tempo sources
	localparam logic [SOURCE_W-1:0] SOURCE_MANUAL = 2'd0;
	localparam logic [SOURCE_W-1:0] SOURCE_TAP    = 2'd1;
	localparam logic [SOURCE_W-1:0] SOURCE_AUTO   = 2'd2;

	// input operations
	localparam logic OP_TAP   = 1'b0;
	localparam logic OP_CLEAR = 1'b1;

	typedef logic [NUM_W-1:0] num_t;
	typedef num_t num_table_t [HISTORY_DEPTH + 1];

	// dividend per held count: one hundred minutes times number of intervals
	function automatic num_table_t build_num_table();
		num_table_t t;
		for (int i = 0; i <= HISTORY_DEPTH; i++) begin
			if (i == 0) begin
				t[i] = '0;
			end else begin
				t[i] = NUM_W'(CENTI_MINUTE_US * 64'(i - 1));
			end
		end
		return t;
	endfunction

	localparam num_table_t NUM_TABLE = build_num_table();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ_PREV,
		ST_CHECK_GAP,
		ST_WRITE,
		ST_READ_OLD,
		ST_LOAD_DIV,
		ST_DIVIDE,
		ST_PUBLISH
	} tte_state_t;

	// controls between the sequencer and the divider
	typedef struct packed {
		logic start;
	} tte_div_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tte_div_stat_t;

endpackage

// ===== hdl/tap_tempo_estimator.sv =====
// tap tempo estimator top level: tap history, gap checks and tempo division
`timescale 1ns / 1ps
//
// channel  | dir | handshake            | payload
// ---------+-----+----------------------+------------------------------------
// input    | in  | in_valid / in_ready  | operation, tap_time_us
// output   | out | out_valid / out_ready| bpm_centi
// config   | in  | cfg_valid / cfg_ready| active_source
//
// a tap that yields a tempo waits on the bit-serial divider, which produces one
// quotient bit per cycle; an ignored tap ends after the gap check, and a clear
// or a first tap ends without starting the divider
// one input transaction is worked at a time; in_ready is high only when idle
// a finished tempo sits in the output register, so the next input transaction
// is taken while out_ready is low; only a second tempo waits for it to drain
// reset clears the history count, write slot, source and output valid
module tap_tempo_estimator
	import tte_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_ready,
	input  logic                operation,
	input  logic [TIME_W-1:0]   tap_time_us,

	output logic                out_valid,
	input  logic                out_ready,
	output logic [BPM_W-1:0]    bpm_centi,

	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [SOURCE_W-1:0] active_source
);

	tte_state_t state_q, state_d;

	// history bookkeeping
	logic [SLOT_W-1:0]   write_slot_q;
	logic [HELD_W-1:0]   taps_held_q;
	logic [SOURCE_W-1:0] source_q;

	// transaction being worked
	logic                operation_q;
	logic [TIME_W-1:0]   now_q;

	// output register
	logic                out_valid_q;
	logic [BPM_W-1:0]    bpm_q;

	// history ram ports
	logic                ram_wr_en;
	logic [SLOT_W-1:0]   ram_rd_addr;
	logic [TIME_W-1:0]   ram_rd_data;

	// divider
	tte_div_ctrl_t       div_ctrl;
	tte_div_stat_t       div_stat;
	num_t                quotient;
	logic [TIME_W-1:0]   span;

	logic                in_fire;
	logic                out_fire;
	logic                publish_ok;
	logic                is_tap_src;

	logic [SLOT_W-1:0]   prev_slot;
	logic [SLOT_W-1:0]   next_slot;
	logic [SLOT_W:0]     old_sum;
	logic [SLOT_W-1:0]   oldest_slot;
	logic signed [TIME_W:0] gap;
	logic                gap_reset;
	logic                gap_bad;
	logic [BPM_W-1:0]    bpm_clamped;

	assign in_fire    = in_valid && in_ready;
	assign out_fire   = out_valid_q && out_ready;
	assign is_tap_src = source_q == SOURCE_TAP;
	assign publish_ok = !out_valid_q || out_ready;
	assign cfg_ready  = 1'b1;

	// slot arithmetic modulo the history depth
	assign prev_slot = (write_slot_q == '0) ? SLOT_W'(HISTORY_DEPTH - 1)
	                                        : write_slot_q - 1'b1;
	assign next_slot = (write_slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
	                                                                : write_slot_q + 1'b1;
	assign old_sum   = (SLOT_W + 1)'({1'b0, write_slot_q} + (SLOT_W + 1)'(HISTORY_DEPTH)
	                   - (SLOT_W + 1)'(taps_held_q));
	assign oldest_slot = (old_sum >= (SLOT_W + 1)'(HISTORY_DEPTH))
	                     ? SLOT_W'(old_sum - (SLOT_W + 1)'(HISTORY_DEPTH))
	                     : old_sum[SLOT_W-1:0];

	// signed gap to the previous tap, exact for any pair of 48-bit times
	assign gap       = $signed({1'b0, now_q}) - $signed({1'b0, ram_rd_data});
	assign gap_reset = gap > GAP_RESET_US;
	assign gap_bad   = (gap < GAP_MIN_US) || (gap > GAP_MAX_US);

	// span newest minus oldest; a zero span makes the quotient all ones,
	// which the clamp turns into the top tempo
	assign span = now_q - ram_rd_data;

	// clamp to the published range
	always_comb begin
		priority if (quotient < num_t'(BPM_CENTI_LOW)) begin
			bpm_clamped = BPM_CENTI_LOW;
		end else if (quotient > num_t'(BPM_CENTI_HIGH)) begin
			bpm_clamped = BPM_CENTI_HIGH;
		end else begin
			bpm_clamped = quotient[BPM_W-1:0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					priority if (operation == OP_CLEAR) begin
						state_d = ST_IDLE;
					end else if (taps_held_q == '0) begin
						state_d = ST_WRITE;
					end else begin
						state_d = ST_READ_PREV;
					end
				end
			end
			ST_READ_PREV: state_d = ST_CHECK_GAP;
			ST_CHECK_GAP: begin
				if (!gap_reset && gap_bad) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_WRITE;
				end
			end
			// a tempo needs at least two taps after this write
			ST_WRITE: state_d = (taps_held_q == '0) ? ST_IDLE : ST_READ_OLD;
			ST_READ_OLD: state_d = ST_LOAD_DIV;
			ST_LOAD_DIV: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (div_stat.done) begin
					state_d = ST_PUBLISH;
				end
			end
			ST_PUBLISH: begin
				if (!is_tap_src || publish_ok) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_ready       = 1'b0;
		ram_wr_en      = 1'b0;
		ram_rd_addr    = prev_slot;
		div_ctrl.start = 1'b0;
		unique case (state_q)
			ST_IDLE:      in_ready = 1'b1;
			ST_READ_PREV: ram_rd_addr = prev_slot;
			ST_CHECK_GAP: ram_rd_addr = prev_slot;
			ST_WRITE:     ram_wr_en = 1'b1;
			ST_READ_OLD:  ram_rd_addr = oldest_slot;
			ST_LOAD_DIV:  div_ctrl.start = 1'b1;
			ST_DIVIDE:    ram_rd_addr = prev_slot;
			ST_PUBLISH:   ram_rd_addr = prev_slot;
			default:      in_ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// history count and write slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot_q <= '0;
			taps_held_q  <= '0;
		end else begin
			if (in_fire && operation == OP_CLEAR) begin
				write_slot_q <= '0;
				taps_held_q  <= '0;
			end else if (state_q == ST_CHECK_GAP && gap_reset) begin
				// long pause: start a fresh history with this tap
				write_slot_q <= '0;
				taps_held_q  <= '0;
			end else if (state_q == ST_WRITE) begin
				write_slot_q <= next_slot;
				if (taps_held_q != HELD_W'(HISTORY_DEPTH)) begin
					taps_held_q <= taps_held_q + 1'b1;
				end
			end
		end
	end

	// selected source
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_q <= SOURCE_MANUAL;
		end else if (cfg_valid && cfg_ready) begin
			source_q <= active_source;
		end
	end

	// captured transaction
	always_ff @(posedge clk) begin
		if (in_fire) begin
			operation_q <= operation;
			now_q       <= tap_time_us;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUBLISH && is_tap_src && publish_ok) begin
			out_valid_q <= 1'b1;
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUBLISH && is_tap_src && publish_ok) begin
			bpm_q <= bpm_clamped;
		end
	end

	assign out_valid = out_valid_q;
	assign bpm_centi = bpm_q;

	tte_ram #(
		.WIDTH(TIME_W),
		.DEPTH(HISTORY_DEPTH)
	) u_history (
		.clk    (clk),
		.wr_en  (ram_wr_en),
		.wr_addr(write_slot_q),
		.wr_data(now_q),
		.rd_addr(ram_rd_addr),
		.rd_data(ram_rd_data)
	);

	tte_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (div_ctrl),
		.dividend(NUM_TABLE[taps_held_q]),
		.divisor (span),
		.stat    (div_stat),
		.quotient(quotient)
	);

	// history bookkeeping stays inside the ring
	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		taps_held_q <= HELD_W'(HISTORY_DEPTH))
		else $error("tap count beyond history depth");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		write_slot_q <= SLOT_W'(HISTORY_DEPTH - 1))
		else $error("write slot beyond history depth");

	// a new tempo only comes from the publish step with the tap source
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_PUBLISH) && $past(is_tap_src))
		else $error("tempo published outside the publish step");

	// published tempo lies in the clamp range
	a_bpm_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (bpm_q >= BPM_CENTI_LOW) && (bpm_q <= BPM_CENTI_HIGH))
		else $error("published tempo out of range");

	// the divider runs only while the sequencer waits for it
	a_div_busy: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> state_q == ST_DIVIDE)
		else $error("divider busy outside the divide step");

	// clear transactions never reach the history write
	a_clear_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> operation_q == OP_TAP)
		else $error("history written for a clear");

endmodule

// ===== hdl/tte_ram.sv =====
// generic single write, single read ram with registered read data
`timescale 1ns / 1ps
module tte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hdl/tte_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module tte_div
	import tte_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  tte_div_ctrl_t       ctrl,
	input  num_t                dividend,
	input  logic [TIME_W-1:0]   divisor,
	output tte_div_stat_t       stat,
	output num_t                quotient
);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	num_t              quo_q;
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] div_q;
	logic [TIME_W:0]   trial;
	logic              fits;

	// shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctrl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(NUM_W);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q && cnt_q != '0) begin
			rem_q <= fits ? TIME_W'(trial - {1'b0, div_q}) : trial[TIME_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = busy_q && (cnt_q == '0);
	assign quotient  = quo_q;

endmodule

// ===== verif/tb_tap_tempo_estimator.sv =====
// self-checking testbench for the tap tempo estimator: directed table, then random tap runs
`timescale 1ns / 1ps
module tb_tap_tempo_estimator;
	import tte_pkg::*;

	// tempo rules kept apart from the rtl package on purpose
	localparam longint LONG_GAP_US  = 2000000;
	localparam longint SHORT_GAP_US = 250000;
	localparam longint MAX_GAP_US   = 1000000;
	localparam logic [63:0] MINUTE_CENTI_US = 64'd6000000000;
	localparam logic [BPM_W-1:0] TEMPO_FLOOR = BPM_W'(6000);
	localparam logic [BPM_W-1:0] TEMPO_CEIL  = BPM_W'(20000);

	// source code with no meaning, still legal on the port
	localparam logic [SOURCE_W-1:0] SOURCE_UNUSED = 2'd3;

	// settle time after the last transaction, with margin over the longest tempo transaction
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 150;

	localparam logic [TIME_W-1:0] T_TOP = '1;
	// ten taps 250 ms apart that end exactly on the top timestamp
	localparam logic [TIME_W-1:0] T_RUN = T_TOP - TIME_W'(2250000);

	typedef struct packed {
		logic               op;
		logic [TIME_W-1:0]  tap_us;
		logic               fixed;
		logic [BPM_W-1:0]   bpm;
	} tap_row_t;

	localparam int ROW_COUNT = 25;

	// fixed rows carry a tempo read straight off the formula, others use the predictor
	localparam tap_row_t TAP_ROWS [ROW_COUNT] = '{
		'{OP_TAP,   TIME_W'(0),       1'b0, BPM_W'(0)},      // first tap after reset
		'{OP_TAP,   TIME_W'(500000),  1'b1, BPM_W'(12000)},  // two taps, 500 ms
		'{OP_TAP,   TIME_W'(750000),  1'b1, BPM_W'(16000)},  // shortest legal gap
		'{OP_TAP,   TIME_W'(1750000), 1'b0, BPM_W'(0)},      // longest legal gap
		'{OP_TAP,   TIME_W'(1999999), 1'b0, BPM_W'(0)},      // one us too short
		'{OP_TAP,   TIME_W'(2750001), 1'b0, BPM_W'(0)},      // one us too long
		'{OP_TAP,   TIME_W'(3750000), 1'b0, BPM_W'(0)},      // exactly 2 s, still ignored
		'{OP_TAP,   TIME_W'(1749999), 1'b0, BPM_W'(0)},      // negative gap
		'{OP_TAP,   TIME_W'(3750001), 1'b0, BPM_W'(0)},      // long gap restarts history
		'{OP_TAP,   TIME_W'(4750001), 1'b1, BPM_W'(6000)},   // slowest tempo, no clamp
		'{OP_TAP,   TIME_W'(5000001), 1'b0, BPM_W'(0)},
		'{OP_CLEAR, T_TOP,            1'b0, BPM_W'(0)},      // clear ignores its timestamp
		'{OP_TAP,   T_RUN,                       1'b0, BPM_W'(0)},
		'{OP_TAP,   T_RUN + TIME_W'(250000),     1'b1, BPM_W'(20000)},
		'{OP_TAP,   T_RUN + TIME_W'(500000),     1'b1, BPM_W'(20000)},
		'{OP_TAP,   T_RUN + TIME_W'(750000),     1'b1, BPM_W'(20000)},
		'{OP_TAP,   T_RUN + TIME_W'(1000000),    1'b1, BPM_W'(20000)},
		'{OP_TAP,   T_RUN + TIME_W'(1250000),    1'b1, BPM_W'(20000)},
		'{OP_TAP,   T_RUN + TIME_W'(1500000),    1'b1, BPM_W'(20000)},
		'{OP_TAP,   T_RUN + TIME_W'(1750000),    1'b1, BPM_W'(20000)},  // ring full
		'{OP_TAP,   T_RUN + TIME_W'(2000000),    1'b1, BPM_W'(20000)},  // oldest overwritten
		'{OP_TAP,   T_TOP,                       1'b1, BPM_W'(20000)},
		'{OP_TAP,   TIME_W'(0),       1'b0, BPM_W'(0)},      // huge negative gap
		'{OP_CLEAR, TIME_W'(0),       1'b0, BPM_W'(0)},
		'{OP_TAP,   TIME_W'(12345),   1'b0, BPM_W'(0)}       // first tap after clear
	};

	// source per random phase; idle mode follows phase number modulo four
	localparam logic [SOURCE_W-1:0] PHASE_SOURCE [PHASE_COUNT] = '{
		SOURCE_TAP, SOURCE_TAP, SOURCE_TAP, SOURCE_TAP,
		SOURCE_MANUAL, SOURCE_AUTO, SOURCE_UNUSED, SOURCE_TAP
	};

	logic                clk;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	logic                operation     = OP_TAP;
	logic [TIME_W-1:0]   tap_time_us   = '0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	logic [BPM_W-1:0]    bpm_centi;
	logic                cfg_valid     = 1'b0;
	logic                cfg_ready;
	logic [SOURCE_W-1:0] active_source = SOURCE_MANUAL;

	// predictor copy of the block state
	logic [TIME_W-1:0]   tap_ring [HISTORY_DEPTH];
	logic [SLOT_W-1:0]   ring_slot;
	logic [HELD_W-1:0]   ring_held;
	logic [SOURCE_W-1:0] tap_source;

	logic [BPM_W-1:0] bpm_expected [$];
	int mismatch_count  = 0;
	int send_idle_pct   = 0;
	int ready_stall_pct = 0;

	tap_tempo_estimator u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.operation     (operation),
		.tap_time_us   (tap_time_us),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.bpm_centi     (bpm_centi),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.active_source (active_source)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	// receiver backpressure, redrawn every cycle
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= ready_stall_pct);
	end

	function automatic void wipe_history();
		foreach (tap_ring[i]) tap_ring[i] = '0;
		ring_slot = '0;
		ring_held = '0;
	endfunction

	// advances the history for one input transaction, returns 1 when a tempo is published
	function automatic bit predict_tempo(input logic op, input logic [TIME_W-1:0] t,
			output logic [BPM_W-1:0] bpm);
		logic [TIME_W-1:0] prev;
		logic [TIME_W-1:0] newest;
		logic [TIME_W-1:0] oldest;
		logic [TIME_W-1:0] span;
		logic [63:0]       quo;
		longint            gap;
		bpm = '0;
		if (op == OP_CLEAR) begin
			wipe_history();
			return 1'b0;
		end
		if (ring_held != 0) begin
			prev = tap_ring[SLOT_W'(ring_slot - 1'b1)];
			gap  = longint'({16'd0, t}) - longint'({16'd0, prev});
			if (gap > LONG_GAP_US) begin
				wipe_history();
			end else if (gap < SHORT_GAP_US || gap > MAX_GAP_US) begin
				return 1'b0;
			end
		end
		tap_ring[ring_slot] = t;
		ring_slot = SLOT_W'(ring_slot + 1'b1);
		if (ring_held < HISTORY_DEPTH) ring_held = ring_held + 1'b1;
		if (ring_held < 2) return 1'b0;
		newest = tap_ring[SLOT_W'(ring_slot - 1'b1)];
		oldest = tap_ring[SLOT_W'(int'(ring_slot) + HISTORY_DEPTH - int'(ring_held))];
		span   = newest - oldest;
		// zero span cannot come from accepted taps, saturate anyway
		if (span == 0) begin
			quo = 64'(TEMPO_CEIL);
		end else begin
			quo = (MINUTE_CENTI_US * 64'(ring_held - 1)) / 64'(span);
		end
		if (quo < 64'(TEMPO_FLOOR)) quo = 64'(TEMPO_FLOOR);
		if (quo > 64'(TEMPO_CEIL)) quo = 64'(TEMPO_CEIL);
		bpm = quo[BPM_W-1:0];
		return tap_source == SOURCE_TAP;
	endfunction

	task automatic note_error(input string what, input logic [BPM_W-1:0] want,
			input logic [BPM_W-1:0] got);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("mismatch at %0t: %s, expected %0d, got %0d", $realtime, what, want, got);
		end
	endtask

	// result checker, compares each tempo transaction with the oldest expectation
	always @(posedge clk) begin : check_tempo
		logic [BPM_W-1:0] want;
		if (arst_n && out_valid && out_ready) begin
			if (bpm_expected.size() == 0) begin
				note_error("tempo with nothing pending", '0, bpm_centi);
			end else begin
				want = bpm_expected.pop_front();
				if (bpm_centi !== want) note_error("bpm_centi", want, bpm_centi);
			end
		end
	end

	// one input transaction; valid stays high until taken
	task automatic send_tap(input logic op, input logic [TIME_W-1:0] t, input logic fixed,
			input logic [BPM_W-1:0] fixed_bpm);
		logic [BPM_W-1:0] bpm;
		bit               has;
		in_valid    <= 1'b1;
		operation   <= op;
		tap_time_us <= t;
		do @(posedge clk); while (!in_ready);
		has = predict_tempo(op, t, bpm);
		if (has) bpm_expected.push_back(fixed ? fixed_bpm : bpm);
	endtask

	// random gap after a transaction, only lowers valid when a gap is taken
	task automatic pause_sender();
		int n;
		n = 0;
		while ($urandom_range(99) < send_idle_pct) n++;
		if (n > 0) begin
			in_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// drain every pending tempo, then let any transaction still inside the block finish
	task automatic settle_block();
		in_valid <= 1'b0;
		while (bpm_expected.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_source(input logic [SOURCE_W-1:0] v);
		cfg_valid     <= 1'b1;
		active_source <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid  <= 1'b0;
		tap_source = v;
	endtask

	// mostly well-formed tap runs, with clears, bad gaps and wild timestamps mixed in
	task automatic pick_tap(output logic op, output logic [TIME_W-1:0] t);
		int unsigned       r;
		logic [TIME_W-1:0] base;
		logic [TIME_W-1:0] wild;
		r    = $urandom_range(99);
		wild = {16'($urandom), 32'($urandom)};
		base = (ring_held != 0) ? tap_ring[SLOT_W'(ring_slot - 1'b1)]
			: TIME_W'($urandom_range(5000000));
		op = OP_TAP;
		if (r < 5) begin
			op = OP_CLEAR;
			t  = wild;
		end else if (r < 11) begin
			t = base + (r[0] ? TIME_W'(SHORT_GAP_US) : TIME_W'(MAX_GAP_US));
		end else if (r < 78) begin
			t = base + TIME_W'($urandom_range(1000000, 250000));
		end else if (r < 84) begin
			t = base + TIME_W'($urandom_range(249999, 0));
		end else if (r < 88) begin
			t = base + TIME_W'($urandom_range(2000000, 1000001));
		end else if (r < 92) begin
			t = base + TIME_W'($urandom_range(4000000, 2000001));
		end else if (r < 96) begin
			t = base - TIME_W'($urandom_range(3000000, 1));
		end else begin
			t = wild;
		end
	endtask

	initial begin : stimulus
		logic              op;
		logic [TIME_W-1:0] t;
		wipe_history();
		tap_source = SOURCE_MANUAL;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table with the tap source selected, no idling
		write_source(SOURCE_TAP);
		foreach (TAP_ROWS[i]) begin
			send_tap(TAP_ROWS[i].op, TAP_ROWS[i].tap_us, TAP_ROWS[i].fixed, TAP_ROWS[i].bpm);
		end

		// random phases, each one starts from an idle block and writes the phase source
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			settle_block();
			write_source(PHASE_SOURCE[phase]);
			case (phase % 4)
				0: begin
					send_idle_pct   = 0;
					ready_stall_pct = 0;
				end
				1: begin
					send_idle_pct   = 58;
					ready_stall_pct = 0;
				end
				2: begin
					send_idle_pct   = 0;
					ready_stall_pct = 58;
				end
				default: begin
					send_idle_pct   = 29;
					ready_stall_pct = 29;
				end
			endcase
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick_tap(op, t);
				send_tap(op, t, 1'b0, '0);
				pause_sender();
			end
		end

		settle_block();
		mismatch_count += bpm_expected.size();
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
